[rtl/utsan_pkg.sv]
`default_nettype none

package utsan_pkg;

  localparam int MAX_CHUNK_BYTES = 4096;
  localparam int SP_W            = 13;
  localparam int PEND_MAX        = (MAX_CHUNK_BYTES < 8191) ? MAX_CHUNK_BYTES : 8191;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

  // classifier verdicts on the head of the window
  localparam logic [1:0] CLS_NEED = 2'd0;
  localparam logic [1:0] CLS_DROP = 2'd1;
  localparam logic [1:0] CLS_TAKE = 2'd2;

  // request kinds from front to back
  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_DROP = 2'd1;
  localparam logic [1:0] EV_END  = 2'd2;

  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] act;
    logic [2:0] len;
  } cls_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bytes;
    logic [2:0]  len;
  } event_t;

  typedef struct packed {
    logic [31:0]     bytes;
    logic [2:0]      len;
    logic [SP_W-1:0] spaces;
    logic            eoc;
    logic            inv;
    logic            nt;
  } result_t;

  function automatic logic [SP_W-1:0] sat_inc(input logic [SP_W-1:0] v);
    sat_inc = (v < SP_W'(PEND_MAX)) ? v + SP_W'(1) : v;
  endfunction

  // strict UTF-8 verdict on n bytes (1..4) starting at b0
  function automatic cls_t utsan_classify(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] n, input logic fin);
    cls_t       r;
    logic [2:0] need;
    logic       bad;
    r.act = CLS_NEED;
    r.len = 3'd0;
    need  = 3'd1;
    bad   = 1'b0;
    if (b0 < 8'h80) begin
      need = 3'd1;
    end else if ((b0 & 8'hE0) == 8'hC0) begin
      need = 3'd2;
      if (b0 < 8'hC2) bad = 1'b1;
    end else if ((b0 & 8'hF0) == 8'hE0) begin
      need = 3'd3;
    end else if ((b0 & 8'hF8) == 8'hF0) begin
      need = 3'd4;
      if (b0 > 8'hF4) bad = 1'b1;
    end else begin
      bad = 1'b1;
    end
    if (need > 3'd1 && n > 3'd1 && (b1 & 8'hC0) != 8'h80) bad = 1'b1;
    if (need > 3'd2 && n > 3'd2 && (b2 & 8'hC0) != 8'h80) bad = 1'b1;
    if (need > 3'd3 && n > 3'd3 && (b3 & 8'hC0) != 8'h80) bad = 1'b1;
    if (n >= 3'd2) begin
      if (b0 == 8'hE0 && b1 <  8'hA0) bad = 1'b1;
      if (b0 == 8'hED && b1 >= 8'hA0) bad = 1'b1;
      if (b0 == 8'hF0 && b1 <  8'h90) bad = 1'b1;
      if (b0 == 8'hF4 && b1 >= 8'h90) bad = 1'b1;
    end
    if (bad) begin
      r.act = CLS_DROP;
      r.len = 3'd1;
    end else if (n < need) begin
      r.act = fin ? CLS_DROP : CLS_NEED;
      r.len = fin ? 3'd1 : 3'd0;
    end else begin
      r.act = CLS_TAKE;
      r.len = need;
    end
    utsan_classify = r;
  endfunction

endpackage

`default_nettype wire

[rtl/utsan_front.sv]
`default_nettype none

module utsan_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [7:0]        in_byte,
  input  wire logic              chunk_last,
  output logic                   full,
  output logic                   ev_push,
  output utsan_pkg::event_t      ev,
  input  wire logic              ev_full
);
  import utsan_pkg::*;

  logic [7:0] win      [4];
  logic [7:0] win_next [4];
  logic [2:0] n, n_next;
  logic       fin, fin_next;
  logic       busy, busy_next;

  logic [7:0] cb [4];
  logic [2:0] cn;
  logic       cfin;
  cls_t       cls;
  logic       push_ok, act, is_end, need_ev, advance;
  logic [2:0] take_len;
  logic [2:0] rem;
  logic [2:0] idx [4];

  // hold off new bytes while the window still has decisions to make or the request queue is full
  assign full    = busy | ev_full;
  assign push_ok = push & ~full;
  assign act     = busy | push_ok;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cb[i] = (!busy && 3'(i) == n) ? in_byte : win[i];
    end
    cn   = busy ? n : n + 3'd1;
    cfin = busy ? fin : chunk_last;
  end

  assign cls      = utsan_classify(cb[0], cb[1], cb[2], cb[3], cn, cfin);
  assign is_end   = (cn == 3'd0);
  assign need_ev  = is_end ? cfin : (cls.act != CLS_NEED);
  assign ev_push  = act & need_ev & ~ev_full;
  assign advance  = act & (~need_ev | ~ev_full);
  assign take_len = (cls.act == CLS_TAKE) ? cls.len : 3'd1;
  assign rem      = cn - take_len;

  always_comb begin
    ev.kind = is_end ? EV_END : ((cls.act == CLS_DROP) ? EV_DROP : EV_CHAR);
    ev.len  = (is_end || cls.act == CLS_DROP) ? 3'd0 : take_len;
    for (int k = 0; k < 4; k++) begin
      ev.bytes[8*k +: 8] = (3'(k) < take_len) ? cb[k] : 8'h00;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      idx[i] = 3'(i) + take_len;
    end
  end

  always_comb begin
    win_next  = win;
    n_next    = n;
    fin_next  = fin;
    busy_next = busy;
    if (advance) begin
      if (is_end) begin
        n_next    = 3'd0;
        fin_next  = 1'b0;
        busy_next = 1'b0;
      end else if (cls.act == CLS_NEED) begin
        win_next  = cb;
        n_next    = cn;
        fin_next  = cfin;
        busy_next = 1'b0;
      end else begin
        // advance the window past the consumed head
        for (int i = 0; i < 4; i++) begin
          win_next[i] = (idx[i] < 3'd4) ? cb[idx[i][1:0]] : cb[i];
        end
        n_next    = rem;
        fin_next  = cfin;
        busy_next = (rem != 3'd0) | cfin;
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (rst) begin
      n    <= 3'd0;
      fin  <= 1'b0;
      busy <= 1'b0;
    end else begin
      n    <= n_next;
      fin  <= fin_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire

[rtl/utsan_evq.sv]
`default_nettype none

module utsan_evq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire utsan_pkg::event_t wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output utsan_pkg::event_t      rd_data,
  output logic                   empty
);
  import utsan_pkg::*;

  event_t            mem [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wp, rp;
  logic [EVQ_AW:0]   cnt;

  assign full    = (cnt == (EVQ_AW+1)'(EVQ_DEPTH));
  assign empty   = (cnt == '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      cnt <= cnt + (EVQ_AW+1)'(wr_en) - (EVQ_AW+1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

[rtl/utsan_back.sv]
`default_nettype none

module utsan_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire utsan_pkg::event_t ev,
  input  wire logic              ev_empty,
  output logic                   ev_pop,
  input  wire logic              pop,
  output logic                   empty,
  output utsan_pkg::result_t     res
);
  import utsan_pkg::*;

  logic [SP_W-1:0] pend, pend_next, p1;
  logic            nonempty, nonempty_next;
  logic            dpend, dpend_next;
  logic            dflag, dflag_next;
  logic            cemit, cemit_next;
  logic            emit;
  result_t         r;
  logic [7:0]      c;

  result_t    rb [2];
  logic       wp, rp;
  logic [1:0] rcnt;
  logic       go, pop_ok, wr;

  assign go     = ~ev_empty & (rcnt != 2'd2);
  assign ev_pop = go;
  assign c      = ev.bytes[7:0];

  always_comb begin
    p1            = (dpend && nonempty && pend == '0) ? sat_inc(pend) : pend;
    pend_next     = pend;
    nonempty_next = nonempty;
    dpend_next    = dpend;
    dflag_next    = dflag;
    cemit_next    = cemit;
    emit          = 1'b0;
    r             = '0;
    case (ev.kind)
      EV_DROP: begin
        dpend_next = 1'b1;
        dflag_next = 1'b1;
      end
      EV_CHAR: begin
        dpend_next = 1'b0;
        if (c == ASCII_NUL) begin
          pend_next = (nonempty && p1 == '0) ? sat_inc(p1) : p1;
        end else if (c == ASCII_SPACE) begin
          pend_next     = sat_inc(p1);
          nonempty_next = 1'b1;
        end else begin
          emit          = 1'b1;
          r.bytes       = ev.bytes;
          r.len         = ev.len;
          r.spaces      = p1;
          pend_next     = '0;
          nonempty_next = 1'b1;
          cemit_next    = 1'b1;
        end
      end
      EV_END: begin
        // close the chunk and drop any trailing spaces
        emit          = 1'b1;
        r.eoc         = 1'b1;
        r.inv         = dflag;
        r.nt          = ~cemit;
        pend_next     = '0;
        nonempty_next = 1'b0;
        dpend_next    = 1'b0;
        dflag_next    = 1'b0;
        cemit_next    = 1'b0;
      end
      default: ;
    endcase
  end

  assign wr     = go & emit;
  assign pop_ok = pop & ~empty;
  assign empty  = (rcnt == 2'd0);
  assign res    = rb[rp];

  always_ff @(posedge clk) begin
    if (wr) rb[wp] <= r;
    if (rst) begin
      pend     <= '0;
      nonempty <= 1'b0;
      dpend    <= 1'b0;
      dflag    <= 1'b0;
      cemit    <= 1'b0;
      wp       <= 1'b0;
      rp       <= 1'b0;
      rcnt     <= 2'd0;
    end else begin
      if (go) begin
        pend     <= pend_next;
        nonempty <= nonempty_next;
        dpend    <= dpend_next;
        dflag    <= dflag_next;
        cemit    <= cemit_next;
      end
      if (wr) wp <= ~wp;
      if (pop_ok) rp <= ~rp;
      rcnt <= rcnt + 2'(wr) - 2'(pop_ok);
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_text_sanitizer_core.sv]
// utf8_text_sanitizer_core: strict UTF-8 sanitizer for a byte-serial text chunk.
// Input queue: drive in_byte/chunk_last with push; a byte is taken at a clock
// edge where push is high and full is low. chunk_last marks the final byte.
// Result queue: while empty is low the oldest result sits on the result ports;
// pop at an edge where empty is low takes it. Each character other than space
// and NUL gives one result with the spaces to emit before it; each chunk closes
// with one result with end_of_chunk set, invalid_seen and no_text.
// Throughput: one byte per cycle for well-formed text while the request queue
// has room. A dropped byte that makes the window decode again holds off input
// while the bytes behind it are re-examined, and the final byte of a chunk
// holds off input for the closing result and any bytes left behind a cut-off
// head. The front decoder issues at most one request per cycle, none while the
// request queue is full. A request waits in the request queue, and its result
// is registered in the result buffer. A four-deep request queue parts decoder
// from space tracker, and a two-entry result buffer lets a stalled receiver
// hold results while bytes still flow; full rises once both fill. Synchronous
// reset empties both queues and clears the window and all chunk state.
`default_nettype none

module utf8_text_sanitizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        chunk_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      char_bytes,
  output logic [2:0]       char_len,
  output logic [12:0]      spaces_before,
  output logic             end_of_chunk,
  output logic             invalid_seen,
  output logic             no_text
);
  import utsan_pkg::*;

  event_t  f_ev, q_ev;
  logic    f_push, q_full, q_empty, q_pop;
  result_t res;

  utsan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_byte    (in_byte),
    .chunk_last (chunk_last),
    .full       (full),
    .ev_push    (f_push),
    .ev         (f_ev),
    .ev_full    (q_full)
  );

  utsan_evq u_evq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_ev),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_ev),
    .empty   (q_empty)
  );

  utsan_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev       (q_ev),
    .ev_empty (q_empty),
    .ev_pop   (q_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign char_bytes    = res.bytes;
  assign char_len      = res.len;
  assign spaces_before = res.spaces;
  assign end_of_chunk  = res.eoc;
  assign invalid_seen  = res.inv;
  assign no_text       = res.nt;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_chunk) |-> (char_len == 3'd0 && spaces_before == 13'd0
                                  && char_bytes == 32'd0))
    else $error("closing result carries character data");

  a_char_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && !end_of_chunk) |-> (char_len != 3'd0 && char_len <= 3'd4
                                   && !invalid_seen && !no_text))
    else $error("character result malformed");

  a_space_cap: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (spaces_before <= 13'(PEND_MAX)))
    else $error("pending space count beyond cap");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import utsan_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int PHASE_BYTES    = 110;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 30;
  localparam int VERDICT_NEED   = 0;
  localparam int VERDICT_DROP   = -1;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        chunk_last = 1'b0;
  logic        full;
  logic        empty;
  logic [31:0] char_bytes;
  logic [2:0]  char_len;
  logic [12:0] spaces_before;
  logic        end_of_chunk;
  logic        invalid_seen;
  logic        no_text;

  utf8_text_sanitizer_core uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .chunk_last    (chunk_last),
    .empty         (empty),
    .pop           (pop),
    .char_bytes    (char_bytes),
    .char_len      (char_len),
    .spaces_before (spaces_before),
    .end_of_chunk  (end_of_chunk),
    .invalid_seen  (invalid_seen),
    .no_text       (no_text)
  );

  feed_t      feed_q[$];
  logic [7:0] chunk_bytes[$];
  result_t    sanitized_q[$];

  // sanitizer state mirrored by the predictor
  logic [7:0]      win_bytes [3];
  int              win_cnt = 0;
  logic [SP_W-1:0] pend_sp = '0;
  logic            out_nonempty = 1'b0;
  logic            drop_run = 1'b0;
  logic            chunk_dropped = 1'b0;
  logic            chunk_had_char = 1'b0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;
  logic took = 1'b0;
  int   err_count = 0;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   chars_checked = 0;
  int   chunks_closed = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("tb: mismatch %s: got 0x%0h, want 0x%0h at cycle %0d",
               what, got, want, cycle_count);
  endtask

  // length of a decodable head, or need / drop
  function automatic int utf8_verdict(input logic [3:0][7:0] w, input int n,
                                      input logic fin);
    logic [7:0] c;
    int         need;
    c = w[0];
    if (c < 8'h80) return 1;
    if ((c & 8'hE0) == 8'hC0) begin
      if (c < 8'hC2) return VERDICT_DROP;
      need = 2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      need = 3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      if (c > 8'hF4) return VERDICT_DROP;
      need = 4;
    end else begin
      return VERDICT_DROP;
    end
    for (int k = 1; k < need && k < n; k++)
      if ((w[k] & 8'hC0) != 8'h80) return VERDICT_DROP;
    if (n >= 2) begin
      if (c == 8'hE0 && w[1] <  8'hA0) return VERDICT_DROP;
      if (c == 8'hED && w[1] >= 8'hA0) return VERDICT_DROP;
      if (c == 8'hF0 && w[1] <  8'h90) return VERDICT_DROP;
      if (c == 8'hF4 && w[1] >= 8'h90) return VERDICT_DROP;
    end
    if (n < need) return fin ? VERDICT_DROP : VERDICT_NEED;
    return need;
  endfunction

  function automatic void clear_sanitizer_state();
    win_cnt        = 0;
    pend_sp        = '0;
    out_nonempty   = 1'b0;
    drop_run       = 1'b0;
    chunk_dropped  = 1'b0;
    chunk_had_char = 1'b0;
  endfunction

  function automatic void bump_spaces();
    if (pend_sp < SP_W'(PEND_MAX)) pend_sp = pend_sp + 1'b1;
  endfunction

  task automatic sanitize_byte(input logic [7:0] b, input logic last);
    logic [3:0][7:0] w;
    int              n;
    int              v;
    int              len;
    result_t         r;
    w = '0;
    n = 0;
    for (int i = 0; i < win_cnt; i++) begin
      w[n] = win_bytes[i];
      n++;
    end
    w[n] = b;
    n++;
    while (n > 0) begin
      v = utf8_verdict(w, n, last);
      if (v == VERDICT_NEED) break;
      if (v == VERDICT_DROP) begin
        drop_run      = 1'b1;
        chunk_dropped = 1'b1;
        len           = 1;
      end else begin
        len = v;
        if (drop_run && out_nonempty && pend_sp == 0) bump_spaces();
        drop_run = 1'b0;
        if (w[0] == ASCII_NUL) begin
          if (out_nonempty && pend_sp == 0) bump_spaces();
        end else if (w[0] == ASCII_SPACE) begin
          bump_spaces();
          out_nonempty = 1'b1;
        end else begin
          r = '0;
          for (int i = 0; i < len; i++) r.bytes[8*i +: 8] = w[i];
          r.len    = 3'(len);
          r.spaces = pend_sp;
          sanitized_q = {sanitized_q, r};
          pend_sp        = '0;
          out_nonempty   = 1'b1;
          chunk_had_char = 1'b1;
        end
      end
      for (int i = 0; i + len < n; i++) w[i] = w[i + len];
      n -= len;
    end
    win_cnt = (n > 3) ? 3 : n;
    for (int i = 0; i < win_cnt; i++) win_bytes[i] = w[i];
    if (last) begin
      r       = '0;
      r.eoc   = 1'b1;
      r.inv   = chunk_dropped;
      r.nt    = !chunk_had_char;
      sanitized_q = {sanitized_q, r};
      clear_sanitizer_state();
    end
  endtask

  // accept requests, predict, and check results
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      took = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (sanitized_q.size() == 0) begin
          report_mismatch("result with nothing pending", char_bytes, 32'h0);
        end else begin
          want = sanitized_q.pop_front();
          if (char_bytes !== want.bytes)
            report_mismatch("char_bytes", char_bytes, want.bytes);
          if (char_len !== want.len)
            report_mismatch("char_len", 32'(char_len), 32'(want.len));
          if (spaces_before !== want.spaces)
            report_mismatch("spaces_before", 32'(spaces_before), 32'(want.spaces));
          if (end_of_chunk !== want.eoc)
            report_mismatch("end_of_chunk", 32'(end_of_chunk), 32'(want.eoc));
          if (invalid_seen !== want.inv)
            report_mismatch("invalid_seen", 32'(invalid_seen), 32'(want.inv));
          if (no_text !== want.nt)
            report_mismatch("no_text", 32'(no_text), 32'(want.nt));
          if (want.eoc) chunks_closed++;
          else chars_checked++;
        end
      end
      took = push && !full;
      if (took) begin
        sanitize_byte(in_byte, chunk_last);
        void'(feed_q.pop_front());
        bytes_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || took) begin
      // hold a request until it is taken
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push       <= 1'b1;
        in_byte    <= feed_q[0].b;
        chunk_last <= feed_q[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rx_hold_left <= 0;
    else if (rx_hold_req) rx_hold_left <= RX_HOLD_CYCLES;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_count, sanitized_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void push_feed(input logic [7:0] b, input logic last);
    feed_t f;
    f.b    = b;
    f.last = last;
    feed_q = {feed_q, f};
  endfunction

  function automatic void chunk_byte(input logic [7:0] b);
    chunk_bytes = {chunk_bytes, b};
  endfunction

  function automatic logic [3:0][7:0] valid_char(input int len);
    logic [3:0][7:0] c;
    c = '0;
    case (len)
      1:       c[0] = 8'($urandom_range(8'h7F, 8'h01));
      2:       c[0] = 8'($urandom_range(8'hDF, 8'hC2));
      3:       c[0] = 8'($urandom_range(8'hEF, 8'hE0));
      default: c[0] = 8'($urandom_range(8'hF4, 8'hF0));
    endcase
    for (int k = 1; k < len; k++) c[k] = 8'($urandom_range(8'hBF, 8'h80));
    // narrow the second byte where the lead restricts it
    if (c[0] == 8'hE0) c[1] = 8'($urandom_range(8'hBF, 8'hA0));
    if (c[0] == 8'hED) c[1] = 8'($urandom_range(8'h9F, 8'h80));
    if (c[0] == 8'hF0) c[1] = 8'($urandom_range(8'hBF, 8'h90));
    if (c[0] == 8'hF4) c[1] = 8'($urandom_range(8'h8F, 8'h80));
    return c;
  endfunction

  function automatic void add_bad_seq();
    case ($urandom_range(7))
      0: chunk_byte(8'($urandom_range(8'hC1, 8'hC0)));
      1: chunk_byte(8'($urandom_range(8'hFF, 8'hF5)));
      2: chunk_byte(8'($urandom_range(8'hBF, 8'h80)));
      3: begin
        chunk_byte(8'hE0);
        chunk_byte(8'($urandom_range(8'h9F, 8'h80)));
      end
      4: begin
        chunk_byte(8'hED);
        chunk_byte(8'($urandom_range(8'hBF, 8'hA0)));
      end
      5: begin
        chunk_byte(8'hF0);
        chunk_byte(8'($urandom_range(8'h8F, 8'h80)));
      end
      6: begin
        chunk_byte(8'hF4);
        chunk_byte(8'($urandom_range(8'hBF, 8'h90)));
      end
      default: begin
        chunk_byte(8'($urandom_range(8'hF4, 8'hC2)));
        chunk_byte(8'($urandom_range(8'h7F, 8'h00)));
      end
    endcase
  endfunction

  task automatic gen_chunk(output int nbytes);
    logic [3:0][7:0] c;
    int              ntok;
    int              len;
    int              cut;
    int              pick;
    chunk_bytes.delete();
    ntok = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
    repeat (ntok) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(4, 1);
        c   = valid_char(len);
        for (int k = 0; k < len; k++) chunk_byte(c[k]);
      end else if (pick < 65) begin
        repeat ($urandom_range(4, 1)) chunk_byte(ASCII_SPACE);
      end else if (pick < 70) begin
        chunk_byte(ASCII_NUL);
      end else if (pick < 82) begin
        add_bad_seq();
      end else if (pick < 90) begin
        // drop the tail of a multibyte character
        len = $urandom_range(4, 2);
        c   = valid_char(len);
        cut = $urandom_range(len - 1, 1);
        for (int k = 0; k < cut; k++) chunk_byte(c[k]);
      end else begin
        chunk_byte(8'($urandom_range(255)));
      end
    end
    foreach (chunk_bytes[i]) push_feed(chunk_bytes[i], i == chunk_bytes.size() - 1);
    nbytes = chunk_bytes.size();
  endtask

  task automatic add_directed();
    // plain text, space run, two- and three-byte maxima, NUL between characters
    push_feed(8'h41, 1'b0); push_feed(ASCII_SPACE, 1'b0); push_feed(ASCII_SPACE, 1'b0);
    push_feed(8'hDF, 1'b0); push_feed(8'hBF, 1'b0); push_feed(ASCII_NUL, 1'b0);
    push_feed(8'hEF, 1'b0); push_feed(8'hBF, 1'b0); push_feed(8'hBF, 1'b1);
    // bad lead, stray continuation, surrogate, too-large, cut-off at the end
    push_feed(8'hC0, 1'b0); push_feed(8'h80, 1'b0); push_feed(8'h41, 1'b0);
    push_feed(8'hED, 1'b0); push_feed(8'hA0, 1'b0); push_feed(8'hF4, 1'b0);
    push_feed(8'h90, 1'b0); push_feed(8'hF0, 1'b0); push_feed(8'h90, 1'b0);
    push_feed(8'h80, 1'b1);
    // only a space, then only a NUL
    push_feed(ASCII_SPACE, 1'b1);
    push_feed(ASCII_NUL, 1'b1);
    // largest four-byte character, then top ASCII
    push_feed(8'hF4, 1'b0); push_feed(8'h8F, 1'b0); push_feed(8'hBF, 1'b0);
    push_feed(8'hBF, 1'b0); push_feed(8'h7F, 1'b1);
    // overlong, 0xFF, and a chunk left with no text at all
    push_feed(8'hE0, 1'b0); push_feed(8'h80, 1'b0); push_feed(8'hFF, 1'b0);
    push_feed(ASCII_SPACE, 1'b0); push_feed(8'hC2, 1'b1);
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || sanitized_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int total;
    int nb;
    clear_sanitizer_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_directed();
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      total = 0;
      while (total < PHASE_BYTES) begin
        gen_chunk(nb);
        total += nb;
      end
      if (ph == 0) begin
        // stall the receiver while bytes keep coming so the block backs up
        @(negedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
        rx_hold_req = 1'b0;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d bytes sent, %0d characters and %0d chunk ends checked",
             bytes_sent, chars_checked, chunks_closed);
    $display("tb: malformed, cut-off and overlong input, NUL, space runs, stalls");
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/utsan_pkg.sv
rtl/utsan_front.sv
rtl/utsan_evq.sv
rtl/utsan_back.sv
rtl/utf8_text_sanitizer_core.sv
dv/tb.sv
